@@ hdl/vfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_pkg: shared types and constants of the ventilation fan alarm step
// Holds the sample and result words, the configuration and latch records,
// register indices, mode bits, build-time path switches and ramp constants.
// ----------------------------------------------------------------------------
package vfa_pkg;

	// Build-time paths for the smoke alarm and the fan fault override.
	localparam logic SMOKE_PATH_ENABLED = 1'b0;
	localparam logic FAN_PATH_ENABLED   = 1'b0;

	// Mode bits.
	localparam logic [2:0] MODE_MANUAL    = 3'b001;
	localparam logic [2:0] MODE_AUTO_TEMP = 3'b010;
	localparam logic [2:0] MODE_AUTO_HUM  = 3'b100;

	// Ramp constants.
	localparam logic [6:0]  FULL_DUTY = 7'd100;
	localparam logic [15:0] RAMP_SPAN = 16'd10;
	localparam logic [10:0] RAMP_HALF = 11'd5;
	// Exact division by ten for dividends up to 1028: (x * 205) >> 11.
	localparam logic [17:0] DIV10_MUL   = 18'd205;
	localparam int          DIV10_SHIFT = 11;

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_SYS_ON          = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE_BITS       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_DUTY     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMP_TARGET     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HUMIDITY_TARGET = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SMOKE_ARM       = 3'd5;

	typedef struct packed {
		logic [15:0] temp_now;
		logic [15:0] humidity_now;
		logic        smoke_seen;
		logic        fan_fault;
		logic        filter_fault;
		logic        clear_level;
	} vfa_in_t;

	typedef struct packed {
		logic [6:0] fan_duty;
		logic       temp_alarm;
		logic       humidity_alarm;
		logic       smoke_alarm;
		logic       fan_alarm_out;
		logic       filter_alarm_out;
	} vfa_out_t;

	typedef struct packed {
		logic        sys_on;
		logic [2:0]  mode_bits;
		logic [7:0]  manual_duty;
		logic [15:0] temp_target;
		logic [15:0] humidity_target;
		logic        smoke_arm;
	} vfa_cfg_t;

	typedef struct packed {
		logic temp;
		logic humidity;
		logic smoke;
		logic fan;
		logic filter;
	} vfa_latch_t;

endpackage
`default_nettype wire

@@ hdl/vfa_chan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_chan: automatic duty and alarm of one sensor channel
// Ramps from the floor duty to full duty over ten units of excess, rounded.
// ----------------------------------------------------------------------------
module vfa_chan
	import vfa_pkg::*;
(
	input  wire logic        enable,
	input  wire logic [15:0] now,
	input  wire logic [15:0] target,
	input  wire logic [6:0]  floor_duty,
	output logic      [6:0]  duty,
	output logic             alarm
);

	logic        above;
	logic [16:0] limit_wide;
	logic [15:0] limit;
	logic [15:0] excess;
	logic        past_span;
	logic [6:0]  span;
	logic [10:0] scaled;
	logic [17:0] recip;
	logic [6:0]  quot;
	logic [7:0]  ramp;

	assign above      = now > target;
	assign limit_wide = {1'b0, target} + {1'b0, RAMP_SPAN};
	assign limit      = limit_wide[16] ? 16'hFFFF : limit_wide[15:0];
	assign excess     = now - target;
	assign past_span  = excess >= RAMP_SPAN;
	assign span       = FULL_DUTY - floor_duty;

	// The excess is below ten whenever the ramp value is used.
	assign scaled = 11'(excess[3:0]) * 11'(span) + RAMP_HALF;
	assign recip  = 18'(scaled) * DIV10_MUL;
	assign quot   = 7'(recip >> DIV10_SHIFT);
	assign ramp   = {1'b0, floor_duty} + {1'b0, quot};

	always_comb begin
		if (!enable || !above) begin
			duty = '0;
		end else if (past_span || ramp > {1'b0, FULL_DUTY}) begin
			duty = FULL_DUTY;
		end else begin
			duty = ramp[6:0];
		end
	end

	assign alarm = enable && above && (now >= limit);

endmodule
`default_nettype wire

@@ hdl/vfa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_ctrl: duty selection and alarm latch update for one sample
// Combines manual and automatic duties, overrides and the clear edge.
// ----------------------------------------------------------------------------
module vfa_ctrl
	import vfa_pkg::*;
(
	input  wire vfa_cfg_t   cfg,
	input  wire vfa_in_t    sample,
	input  wire vfa_latch_t latch,
	input  wire logic       prev_clear,
	output vfa_latch_t      latch_next,
	output vfa_out_t        result
);

	logic       manual;
	logic [6:0] min_duty;
	logic [6:0] temp_duty;
	logic [6:0] hum_duty;
	logic       temp_auto_alarm;
	logic       hum_auto_alarm;
	logic       temp_alarm;
	logic       hum_alarm;
	logic       smoke_on;
	logic       smoke_act;
	logic       fan_act;
	logic       clear_req;
	logic [6:0] duty;
	vfa_latch_t base;
	vfa_latch_t act;

	assign manual   = |(cfg.mode_bits & MODE_MANUAL);
	assign min_duty = (cfg.manual_duty > {1'b0, FULL_DUTY}) ? FULL_DUTY : cfg.manual_duty[6:0];

	vfa_chan u_temp (
		.enable     (!manual && |(cfg.mode_bits & MODE_AUTO_TEMP)),
		.now        (sample.temp_now),
		.target     (cfg.temp_target),
		.floor_duty (min_duty),
		.duty       (temp_duty),
		.alarm      (temp_auto_alarm)
	);

	vfa_chan u_hum (
		.enable     (!manual && |(cfg.mode_bits & MODE_AUTO_HUM)),
		.now        (sample.humidity_now),
		.target     (cfg.humidity_target),
		.floor_duty (min_duty),
		.duty       (hum_duty),
		.alarm      (hum_auto_alarm)
	);

	always_comb begin
		if (manual) begin
			duty       = min_duty;
			temp_alarm = {1'b0, sample.temp_now} >= ({1'b0, cfg.temp_target} + {1'b0, RAMP_SPAN});
			hum_alarm  = {1'b0, sample.humidity_now} >=
				({1'b0, cfg.humidity_target} + {1'b0, RAMP_SPAN});
		end else begin
			duty       = (temp_duty > hum_duty) ? temp_duty : hum_duty;
			temp_alarm = temp_auto_alarm;
			hum_alarm  = hum_auto_alarm;
		end
	end

	assign smoke_on  = SMOKE_PATH_ENABLED && cfg.smoke_arm;
	assign smoke_act = smoke_on && sample.smoke_seen;
	assign fan_act   = FAN_PATH_ENABLED && sample.fan_fault;
	assign clear_req = prev_clear && !sample.clear_level;

	always_comb begin
		base        = latch;
		base.smoke  = smoke_on && latch.smoke;
		base.fan    = FAN_PATH_ENABLED && latch.fan;
		act.temp     = temp_alarm;
		act.humidity = hum_alarm;
		act.smoke    = smoke_act;
		act.fan      = fan_act;
		act.filter   = sample.filter_fault;
	end

	always_comb begin
		if (!cfg.sys_on) begin
			latch_next      = '0;
			result.fan_duty = '0;
		end else begin
			// A clear edge drops only the latches whose condition is gone.
			latch_next = (base | act) & ~({$bits(vfa_latch_t){clear_req}} & ~act);
			if (fan_act) begin
				result.fan_duty = '0;
			end else if (smoke_act) begin
				result.fan_duty = FULL_DUTY;
			end else begin
				result.fan_duty = duty;
			end
		end
		result.temp_alarm       = latch_next.temp;
		result.humidity_alarm   = latch_next.humidity;
		result.smoke_alarm      = latch_next.smoke;
		result.fan_alarm_out    = latch_next.fan;
		result.filter_alarm_out = latch_next.filter;
	end

endmodule
`default_nettype wire

@@ hdl/ventilation_fan_alarm_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ventilation_fan_alarm_step: fan duty and latched alarms per sensor sample
// Sample register, single-pass control logic, alarm latches and result
// register, with a plain configuration write port.
// ----------------------------------------------------------------------------
// Usage:
// Each sample word carries the temperature and humidity readings, the three
// fault flags and the alarm clear level. Every sample yields exactly one
// result word: the fan duty (0 to 100) and the five alarm latches as they
// stand after that sample.
// Both channels use valid and stall; a word moves on an edge where valid is
// high and stall is low. A sample accepted on one edge is registered, worked
// through the control logic and loaded into the result register as soon as
// that register can load, and is offered from there. One sample is accepted
// in every cycle while the result side keeps up; the alarm latches are
// updated in the same cycle the result register loads, so back-to-back
// samples see each other's state. When the receiver stalls, the result is
// held and the sample register fills; the sample channel then stalls until
// the result word is taken.
// Reset clears the configuration registers, the latches, the stored clear
// level and both valid flags. Configuration is written through cfg_we,
// cfg_index and cfg_data; unknown indices are ignored. The user must write
// it only while no sample is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module ventilation_fan_alarm_step
	import vfa_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire vfa_in_t                sample,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output vfa_out_t                    result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	vfa_cfg_t   cfg_q;
	vfa_latch_t latch_q;
	logic       prev_clear_q;
	logic       valid_s1;
	vfa_in_t    sample_s1;
	logic       result_valid_q;
	vfa_out_t   result_q;
	logic       advance;
	vfa_latch_t latch_next;
	vfa_out_t   result_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYS_ON:          cfg_q.sys_on          <= cfg_data[0];
				REG_MODE_BITS:       cfg_q.mode_bits       <= cfg_data[2:0];
				REG_MANUAL_DUTY:     cfg_q.manual_duty     <= cfg_data[7:0];
				REG_TEMP_TARGET:     cfg_q.temp_target     <= cfg_data;
				REG_HUMIDITY_TARGET: cfg_q.humidity_target <= cfg_data;
				REG_SMOKE_ARM:       cfg_q.smoke_arm       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The result register can load when it is empty or being taken.
	assign advance      = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;

	// Sample register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	vfa_ctrl u_ctrl (
		.cfg        (cfg_q),
		.sample     (sample_s1),
		.latch      (latch_q),
		.prev_clear (prev_clear_q),
		.latch_next (latch_next),
		.result     (result_next)
	);

	// Alarm latches and the stored clear level move with each sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q        <= '0;
			prev_clear_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				latch_q      <= latch_next;
				prev_clear_q <= sample_s1.clear_level;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

@@ hdl/vfa_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vfa_checker: port-level checks on the result channel
// Checks that the result word is held under stall, the duty range and absent paths.
// ----------------------------------------------------------------------------
module vfa_checker
	import vfa_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     result_valid,
	input wire logic     result_stall,
	input wire vfa_out_t result
);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.fan_duty <= FULL_DUTY)
		else $error("fan duty above full scale");

	a_no_smoke: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !SMOKE_PATH_ENABLED |-> !result.smoke_alarm)
		else $error("smoke alarm raised without the smoke path");

	a_no_fan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !FAN_PATH_ENABLED |-> !result.fan_alarm_out)
		else $error("fan alarm raised without the fan path");

endmodule

bind ventilation_fan_alarm_step vfa_checker u_vfa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire

@@ dv/ventilation_fan_alarm_step_tb.sv @@
// ----------------------------------------------------------------------------
// ventilation_fan_alarm_step_tb: self-checking bench for the fan alarm step
// Drives sensor sample words through the valid/stall channel, predicts every
// result word with a behavioural model of the duty ramp and the alarm
// latches, and compares each result field by field as it is taken. The
// configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module ventilation_fan_alarm_step_tb
	import vfa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Mode words that are not single bits of the package.
	localparam logic [2:0] MODE_OFF = 3'b000;
	localparam logic [2:0] MODE_AUTO_BOTH = MODE_AUTO_TEMP | MODE_AUTO_HUM;
	localparam logic [2:0] MODE_ALL = MODE_MANUAL | MODE_AUTO_TEMP | MODE_AUTO_HUM;

	// A correct run stays well within this limit.
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam int RANDOM_PHASES = 5;
	localparam int WORDS_PER_PHASE = 100;

	// All inputs of the block start from known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	vfa_in_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	vfa_out_t result;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SYS_ON;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ventilation_fan_alarm_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Sample words waiting to be offered, and the status words that the
	// accepted samples are predicted to produce, oldest first.
	vfa_in_t samples_to_send[$];
	vfa_out_t fan_status_due[$];
	vfa_out_t due_word;

	// The bench's own copy of the configuration, the alarm latches and the
	// last clear level. All of them are zero after reset.
	vfa_cfg_t settings = '0;
	vfa_latch_t alarms = '0;
	logic last_clear = 1'b0;

	// Idling controls, set by the stimulus process between phases.
	int send_gap_max = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;

	int error_count = 0;
	int cycle_count = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Duty of one auto channel. The duty ramps from the floor duty up to full
	// duty as the reading climbs over the target by up to one ramp span, with
	// rounding to the nearest percent. The alarm threshold is the target plus
	// the span, clamped at the top of the 16-bit range, so a target near the
	// top can still alarm.
	function automatic int unsigned ramp_channel(input int unsigned now,
			input int unsigned target, input int unsigned floor_duty, output logic alarm);
		int unsigned span;
		int unsigned full;
		int unsigned limit;
		int unsigned excess;
		int unsigned duty;
		span = 32'(RAMP_SPAN);
		full = 32'(FULL_DUTY);
		if (now <= target) begin
			alarm = 1'b0;
			return 0;
		end
		limit = target + span;
		if (limit > 16'hFFFF)
			limit = 16'hFFFF;
		alarm = now >= limit;
		excess = now - target;
		if (excess >= span)
			return full;
		duty = floor_duty + (excess * (full - floor_duty) + span / 2) / span;
		return (duty > full) ? full : duty;
	endfunction

	// Works out the status word for one accepted sample and advances the
	// latches and the stored clear level exactly as the block should.
	function automatic vfa_out_t next_fan_status(input vfa_in_t s);
		vfa_out_t word;
		logic t_hit;
		logic h_hit;
		logic smoke_on;
		logic smoke_hit;
		logic fan_hit;
		logic clear_edge;
		int unsigned span;
		int unsigned full;
		int unsigned floor_duty;
		int unsigned duty;
		int unsigned t_duty;
		int unsigned h_duty;
		word = '0;
		span = 32'(RAMP_SPAN);
		full = 32'(FULL_DUTY);

		// A disabled system forgets every alarm and reports nothing, but
		// still tracks the clear level.
		if (!settings.sys_on) begin
			alarms = '0;
			last_clear = s.clear_level;
			return word;
		end

		// Paths that are not built in, or not enabled, keep their latch low.
		smoke_on = SMOKE_PATH_ENABLED && settings.smoke_arm;
		if (!smoke_on)
			alarms.smoke = 1'b0;
		if (!FAN_PATH_ENABLED)
			alarms.fan = 1'b0;
		smoke_hit = smoke_on && s.smoke_seen;
		fan_hit = FAN_PATH_ENABLED && s.fan_fault;

		floor_duty = (settings.manual_duty > full) ? full : 32'(settings.manual_duty);
		t_hit = 1'b0;
		h_hit = 1'b0;
		t_duty = 0;
		h_duty = 0;
		if ((settings.mode_bits & MODE_MANUAL) != MODE_OFF) begin
			// Manual mode: the threshold sum is taken wide, so a target near the
			// top of the range never alarms.
			duty = floor_duty;
			t_hit = int'(s.temp_now) >= int'(settings.temp_target) + int'(span);
			h_hit = int'(s.humidity_now) >= int'(settings.humidity_target) + int'(span);
		end else begin
			// Auto mode: each enabled channel ramps on its own, the larger wins,
			// and a channel that is not enabled neither drives nor alarms.
			if ((settings.mode_bits & MODE_AUTO_TEMP) != MODE_OFF)
				t_duty = ramp_channel(32'(s.temp_now), 32'(settings.temp_target),
					floor_duty, t_hit);
			if ((settings.mode_bits & MODE_AUTO_HUM) != MODE_OFF)
				h_duty = ramp_channel(32'(s.humidity_now), 32'(settings.humidity_target),
					floor_duty, h_hit);
			duty = (t_duty > h_duty) ? t_duty : h_duty;
		end

		if (t_hit)
			alarms.temp = 1'b1;
		if (h_hit)
			alarms.humidity = 1'b1;
		if (smoke_hit)
			alarms.smoke = 1'b1;
		if (fan_hit)
			alarms.fan = 1'b1;
		if (s.filter_fault)
			alarms.filter = 1'b1;

		// A falling clear level drops only the alarms whose cause has gone.
		clear_edge = last_clear && !s.clear_level;
		last_clear = s.clear_level;
		if (clear_edge) begin
			if (!t_hit)
				alarms.temp = 1'b0;
			if (!h_hit)
				alarms.humidity = 1'b0;
			if (!smoke_hit)
				alarms.smoke = 1'b0;
			if (!fan_hit)
				alarms.fan = 1'b0;
			if (!s.filter_fault)
				alarms.filter = 1'b0;
		end

		// Smoke drives the fan flat out; a fan fault overrides even that.
		if (smoke_hit)
			duty = full;
		if (fan_hit)
			duty = 0;

		word.fan_duty = duty[6:0];
		word.temp_alarm = alarms.temp;
		word.humidity_alarm = alarms.humidity;
		word.smoke_alarm = alarms.smoke;
		word.fan_alarm_out = alarms.fan;
		word.filter_alarm_out = alarms.filter;
		return word;
	endfunction

	// Sender. A word is taken on an edge where valid is high and stall is low;
	// its prediction is made there and then, so the expectations stay in the
	// order the block sees the samples. The next word, or a gap, is only set
	// up once the slot is free, so a stalled word never changes. Bursts of
	// random length alternate with gaps of random length.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				fan_status_due.push_back(next_fan_status(sample));
			if (!sample_valid || !sample_stall) begin
				if (gap_left != 0) begin
					gap_left = gap_left - 1;
					sample_valid <= 1'b0;
				end else if (samples_to_send.size() != 0) begin
					sample <= samples_to_send.pop_front();
					sample_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
					end else begin
						burst_left = burst_left - 1;
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. It stalls at random at the rate of the current phase. When the
	// stimulus process flips the hold request, it holds off for a long stretch
	// of its own counting, which backs the block up into its sample channel.
	logic hold_seen = 1'b0;
	int hold_left = 0;

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic compare_field(input string name, input logic [6:0] want,
			input logic [6:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Checker. Every word taken from the block is matched against the oldest
	// prediction; a word with nothing predicted is an error on its own.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (fan_status_due.size() == 0) begin
				error_count++;
				$display("%0t: result word expected none, got %h", $time, result);
			end else begin
				due_word = fan_status_due.pop_front();
				compare_field("fan_duty", due_word.fan_duty, result.fan_duty);
				compare_field("temp_alarm", 7'(due_word.temp_alarm), 7'(result.temp_alarm));
				compare_field("humidity_alarm", 7'(due_word.humidity_alarm),
					7'(result.humidity_alarm));
				compare_field("smoke_alarm", 7'(due_word.smoke_alarm),
					7'(result.smoke_alarm));
				compare_field("fan_alarm_out", 7'(due_word.fan_alarm_out),
					7'(result.fan_alarm_out));
				compare_field("filter_alarm_out", 7'(due_word.filter_alarm_out),
					7'(result.filter_alarm_out));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ventilation_fan_alarm_step_tb: done, errors");
			$finish;
		end
	end

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Writes every register and mirrors the new settings into the model.
	// Only called while nothing is in flight.
	task automatic apply_settings(input logic en, input logic [2:0] mode,
			input logic [7:0] duty, input logic [15:0] t_target, input logic [15:0] h_target,
			input logic smoke_en);
		write_register(REG_SYS_ON, CFG_DATA_W'(en));
		write_register(REG_MODE_BITS, CFG_DATA_W'(mode));
		write_register(REG_MANUAL_DUTY, CFG_DATA_W'(duty));
		write_register(REG_TEMP_TARGET, t_target);
		write_register(REG_HUMIDITY_TARGET, h_target);
		write_register(REG_SMOKE_ARM, CFG_DATA_W'(smoke_en));
		settings = '{sys_on: en, mode_bits: mode, manual_duty: duty,
			temp_target: t_target, humidity_target: h_target, smoke_arm: smoke_en};
	endtask

	// Waits until every queued word has been sent and every prediction has
	// been met, then lets the pipeline settle. Checked on the falling
	// edge so that the queues are never read while the clocked blocks move.
	task automatic drain_and_settle();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || sample_valid || fan_status_due.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic offer(input logic [15:0] t_now, input logic [15:0] h_now,
			input logic smoke, input logic fan, input logic filter, input logic clr);
		samples_to_send.push_back('{temp_now: t_now, humidity_now: h_now, smoke_seen: smoke,
			fan_fault: fan, filter_fault: filter, clear_level: clr});
	endtask

	// Readings mostly sit just around the target, where the ramp and the
	// alarm thresholds live, and otherwise span the whole range.
	function automatic logic [15:0] near_target(input logic [15:0] target);
		if ($urandom_range(0, 9) < 7)
			return target + 16'($urandom_range(0, 13)) - 16'd2;
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [15:0] pick_target();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'hFFFA;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [7:0] pick_duty();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd100;
			2: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic vfa_in_t random_sample();
		vfa_in_t s;
		s.temp_now = near_target(settings.temp_target);
		s.humidity_now = near_target(settings.humidity_target);
		s.smoke_seen = $urandom_range(0, 3) == 0;
		s.fan_fault = $urandom_range(0, 3) == 0;
		s.filter_fault = $urandom_range(0, 3) == 0;
		s.clear_level = 1'($urandom_range(0, 1));
		return s;
	endfunction

	// Stimulus and end of run.
	initial begin
		int phase;
		int n;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset settings the system is disabled: everything reads
		// zero, and the clear level falls without effect.
		offer(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
		offer(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
		drain_and_settle();

		// Manual mode with an oversized duty, which saturates to full. The
		// temperature threshold lies beyond the range and never alarms; the
		// humidity one sits exactly at the top. Smoke and fan faults have no
		// path. A falling clear keeps the filter alarm while the fault is
		// still there and drops it once it has gone.
		apply_settings(1'b1, MODE_MANUAL, 8'd255, 16'hFFFF, 16'hFFF5, 1'b1);
		offer(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
		offer(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
		offer(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1);
		offer(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
		drain_and_settle();

		// Auto on both channels from a zero floor. The temperature target is
		// so high that its threshold clamps at the top of the range; the
		// ramp is hit at its low, middle and full ends, then cleared.
		apply_settings(1'b1, MODE_AUTO_BOTH, 8'd0, 16'hFFFA, 16'd1000, 1'b0);
		offer(16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(16'hFFFB, 16'd1009, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(16'hFFFA, 16'd1010, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(16'd0, 16'd1005, 1'b0, 1'b0, 1'b0, 1'b1);
		offer(16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		drain_and_settle();

		// Humidity only: the temperature channel neither drives nor alarms.
		apply_settings(1'b1, MODE_AUTO_HUM, 8'd60, 16'd0, 16'd0, 1'b0);
		offer(16'd5, 16'd5, 1'b0, 1'b0, 1'b0, 1'b0);
		offer(16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		drain_and_settle();

		// Auto with no channel bits gives no drive at all.
		apply_settings(1'b1, MODE_OFF, 8'd50, 16'd0, 16'd0, 1'b0);
		offer(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
		drain_and_settle();

		// All mode bits: manual takes precedence over auto.
		apply_settings(1'b1, MODE_ALL, 8'd100, 16'd0, 16'd0, 1'b1);
		offer(16'd9, 16'd10, 1'b0, 1'b0, 1'b1, 1'b0);
		drain_and_settle();

		// Disabling the system wipes the latched alarms.
		apply_settings(1'b0, MODE_ALL, 8'd100, 16'd0, 16'd0, 1'b1);
		offer(16'd20, 16'd20, 1'b1, 1'b1, 1'b1, 1'b1);
		drain_and_settle();

		// Random phases. The first one runs without any idling and holds the
		// receiver off for a long stretch while words keep coming; the others
		// idle both sides at random. Each phase ends with the sender waiting
		// for every result before the settings change.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: apply_settings(1'b1, MODE_AUTO_BOTH, 8'd100, 16'd0, 16'hFFFF, 1'b1);
				1: apply_settings(1'b1, MODE_ALL, 8'd0, 16'hFFFF, 16'd0, 1'b0);
				default: apply_settings($urandom_range(0, 7) != 0, 3'($urandom_range(0, 7)),
					pick_duty(), pick_target(), pick_target(), 1'($urandom_range(0, 1)));
			endcase
			@(negedge clk);
			send_gap_max = (phase == 0) ? 0 : $urandom_range(1, 8);
			stall_pct = (phase == 0) ? 0 : $urandom_range(10, 60);
			for (n = 0; n < WORDS_PER_PHASE; n++)
				samples_to_send.push_back(random_sample());
			if (phase == 0) begin
				repeat (20) @(negedge clk);
				hold_req = ~hold_req;
			end
			drain_and_settle();
		end

		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("ventilation_fan_alarm_step_tb: done, clean");
		else
			$display("ventilation_fan_alarm_step_tb: done, errors");
		$finish;
	end

endmodule
